// ===== rtl/core/morse_text_decoder_defines.svh =====
// ---------------------------------------------------------------------------
// Morse text decoder assertion macros
// Shared property macros for the decoder core, clocked on clk and disabled
// while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MORSE_TEXT_DECODER_DEFINES_SVH
`define MORSE_TEXT_DECODER_DEFINES_SVH

// Same-cycle implication
`define MTD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("morse_text_decoder: same-cycle check failed");

// Next-cycle implication
`define MTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("morse_text_decoder: next-cycle check failed");

`endif

// ===== rtl/core/mtd_pkg.sv =====
// ---------------------------------------------------------------------------
// Morse text decoder package
// Types, byte codes and the letter table shared by the decoder core.
// ---------------------------------------------------------------------------
`default_nettype none

package mtd_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [2:0] MAX_ELEMENTS = 3'd4;

    // Notation bytes
    localparam logic [7:0] BYTE_NUL        = 8'h00;
    localparam logic [7:0] BYTE_TAB        = 8'h09;
    localparam logic [7:0] BYTE_LF         = 8'h0A;
    localparam logic [7:0] BYTE_CR         = 8'h0D;
    localparam logic [7:0] BYTE_SPACE      = 8'h20;
    localparam logic [7:0] BYTE_DASH       = 8'h2D;
    localparam logic [7:0] BYTE_DOT        = 8'h2E;
    localparam logic [7:0] BYTE_SLASH      = 8'h2F;
    localparam logic [7:0] BYTE_UNDERSCORE = 8'h5F;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NONE  = 8'h00;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        logic [3:0] element_bits;
        logic [2:0] element_count;
        logic       failed;
    } dec_state_t;

    typedef struct packed {
        logic [7:0] char_code;
        kind_t      kind;
        logic       last;
    } result_t;

    typedef struct packed {
        dec_state_t next_state;
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } dec_out_t;

    // Letter alphabet, indexed by element bits plus 2^count - 1
    function automatic logic [7:0] letter_lookup(input logic [4:0] idx);
        logic [7:0] code;
        unique case (idx)
            5'd0:  code = 8'h20;
            5'd1:  code = "E";
            5'd2:  code = "T";
            5'd3:  code = "I";
            5'd4:  code = "N";
            5'd5:  code = "A";
            5'd6:  code = "M";
            5'd7:  code = "S";
            5'd8:  code = "D";
            5'd9:  code = "R";
            5'd10: code = "G";
            5'd11: code = "U";
            5'd12: code = "K";
            5'd13: code = "W";
            5'd14: code = "O";
            5'd15: code = "H";
            5'd16: code = "B";
            5'd17: code = "L";
            5'd18: code = "Z";
            5'd19: code = "F";
            5'd20: code = "C";
            5'd21: code = "P";
            5'd22: code = 8'hD6;
            5'd23: code = "V";
            5'd24: code = "X";
            5'd25: code = 8'hC4;
            5'd26: code = "Q";
            5'd27: code = 8'hDC;
            5'd28: code = "Y";
            5'd29: code = "J";
            default: code = 8'h23;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/morse_text_decoder.sv =====
// ---------------------------------------------------------------------------
// Morse text decoder
// Decodes a byte stream of dot/dash notation into Latin-1 characters.
// ---------------------------------------------------------------------------
// Usage:
//   The slave channel takes one notation byte per transfer on s_tdata.
//   The master channel gives one result per transfer: the character code on
//   m_tdata, the result kind on m_tuser (character, end of text, error) and
//   m_tlast on the final result caused by an input byte.
//   A byte is held in an input register and decoded from there into
//   zero, one or two results, which are pushed into a small result queue
//   (FIFO_DEPTH entries); results are offered from the queue head.
//   Throughput is one byte per cycle while each byte gives at most one
//   result and the receiver keeps up; a byte giving two results needs two
//   transfers on the single master port.
//   The input register advances only when the queue has room for two
//   results, so a stalled receiver fills the queue and then holds s_tready
//   low; no result is dropped.
//   Reset clears the pending letter, the error flag, the input register and
//   the queue; s_tready is high straight after reset.
// ---------------------------------------------------------------------------
`default_nettype none

`include "morse_text_decoder_defines.svh"

module morse_text_decoder
#(
    parameter int FIFO_DEPTH = mtd_pkg::FIFO_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] text_byte

    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] char_code
    output logic [1:0]      m_tuser,   // [1:0] kind
    output logic            m_tlast    // last
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    mtd_pkg::dec_state_t state_reg;
    mtd_pkg::dec_out_t   dec;

    mtd_pkg::result_t    fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    wr_ptr_p1;
    logic [PTR_W-1:0]    wr_ptr_p2;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    logic                advance;
    logic                pop;
    logic [CNT_W-1:0]    push_n;
    mtd_pkg::result_t    head;

    mtd_decode u_decode
    (
        .text_byte (in_byte_reg),
        .state     (state_reg),
        .dec       (dec)
    );

    // Advance only with room for the largest burst of results
    assign advance  = in_valid_reg && (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign s_tready = !in_valid_reg || advance;
    assign pop      = m_tvalid && m_tready;
    assign push_n   = advance ? CNT_W'(dec.count) : '0;

    assign wr_ptr_p1 = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign wr_ptr_p2 = (wr_ptr_p1 == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_p1 + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push_n == CNT_W'(1))
        begin
            wr_ptr_next = wr_ptr_p1;
        end
        else if (push_n == CNT_W'(2))
        begin
            wr_ptr_next = wr_ptr_p2;
        end
    end

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    assign count_next = count_reg + push_n - (pop ? CNT_W'(1) : CNT_W'(0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                state_reg <= dec.next_state;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload: input byte and queue entries
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance && (dec.count != 2'd0))
        begin
            fifo_reg[wr_ptr_reg] <= dec.res0;
        end
        if (advance && (dec.count == 2'd2))
        begin
            fifo_reg[wr_ptr_p1] <= dec.res1;
        end
    end

    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = head.char_code;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

    `MTD_ASSERT_NOW(a_fifo_bound, 1'b1, count_reg <= CNT_W'(FIFO_DEPTH))
    `MTD_ASSERT_NOW(a_failed_no_letter, state_reg.failed, state_reg.element_count == 3'd0)
    `MTD_ASSERT_NOW(a_letter_length, 1'b1, state_reg.element_count <= mtd_pkg::MAX_ELEMENTS)
    `MTD_ASSERT_NEXT(a_push_visible, advance && (dec.count != 2'd0), m_tvalid)

endmodule

`default_nettype wire

// ===== rtl/core/mtd_decode.sv =====
// ---------------------------------------------------------------------------
// Morse text decoder step logic
// Combinational decode of one notation byte against the pending letter,
// giving the next letter state and up to two results.
// ---------------------------------------------------------------------------
`default_nettype none

module mtd_decode
(
    input  wire logic [7:0]         text_byte,
    input  wire mtd_pkg::dec_state_t state,
    output mtd_pkg::dec_out_t       dec
);

    logic                flush_valid;
    logic [4:0]          letter_idx;
    mtd_pkg::result_t    flush_res;
    mtd_pkg::result_t    err_res;
    mtd_pkg::result_t    end_res;
    mtd_pkg::result_t    space_res;
    mtd_pkg::dec_state_t cleared;
    mtd_pkg::dec_out_t   d;

    assign flush_valid = (state.element_count != 3'd0);
    assign letter_idx  = {1'b0, state.element_bits}
                       + ((5'd1 << state.element_count) - 5'd1);

    assign flush_res = '{char_code: mtd_pkg::letter_lookup(letter_idx),
                         kind: mtd_pkg::KIND_CHAR, last: 1'b0};
    assign err_res   = '{char_code: mtd_pkg::CHAR_NONE,
                         kind: mtd_pkg::KIND_ERROR, last: 1'b0};
    assign end_res   = '{char_code: mtd_pkg::CHAR_NONE,
                         kind: mtd_pkg::KIND_END, last: 1'b0};
    assign space_res = '{char_code: mtd_pkg::CHAR_SPACE,
                         kind: mtd_pkg::KIND_CHAR, last: 1'b0};
    assign cleared   = '{element_bits: 4'd0, element_count: 3'd0, failed: 1'b0};

    always_comb
    begin
        d.next_state = state;
        d.count      = 2'd0;
        d.res0       = space_res;
        d.res1       = space_res;

        if (state.failed)
        begin
            // Ignore everything up to end of text
            if (text_byte == mtd_pkg::BYTE_NUL)
            begin
                d.next_state = cleared;
                d.res0       = end_res;
                d.count      = 2'd1;
            end
        end
        else
        begin
            unique case (text_byte)
                mtd_pkg::BYTE_DOT, mtd_pkg::BYTE_DASH, mtd_pkg::BYTE_UNDERSCORE:
                begin
                    if (state.element_count >= mtd_pkg::MAX_ELEMENTS)
                    begin
                        d.next_state        = cleared;
                        d.next_state.failed = 1'b1;
                        d.res0              = err_res;
                        d.count             = 2'd1;
                    end
                    else
                    begin
                        if (text_byte != mtd_pkg::BYTE_DOT)
                        begin
                            d.next_state.element_bits = state.element_bits
                                | (4'd1 << state.element_count[1:0]);
                        end
                        d.next_state.element_count = state.element_count + 3'd1;
                    end
                end
                mtd_pkg::BYTE_SPACE, mtd_pkg::BYTE_TAB,
                mtd_pkg::BYTE_LF, mtd_pkg::BYTE_CR:
                begin
                    d.next_state = cleared;
                    d.res0       = flush_res;
                    d.count      = flush_valid ? 2'd1 : 2'd0;
                end
                mtd_pkg::BYTE_SLASH, mtd_pkg::BYTE_NUL:
                begin
                    // Flush the pending letter, then the word space or end marker
                    d.next_state = cleared;
                    if (flush_valid)
                    begin
                        d.res0  = flush_res;
                        d.res1  = (text_byte == mtd_pkg::BYTE_NUL) ? end_res : space_res;
                        d.count = 2'd2;
                    end
                    else
                    begin
                        d.res0  = (text_byte == mtd_pkg::BYTE_NUL) ? end_res : space_res;
                        d.count = 2'd1;
                    end
                end
                default:
                begin
                    d.next_state        = cleared;
                    d.next_state.failed = 1'b1;
                    d.res0              = err_res;
                    d.count             = 2'd1;
                end
            endcase
        end

        // Mark the final result of this byte
        if (d.count == 2'd1)
        begin
            d.res0.last = 1'b1;
        end
        if (d.count == 2'd2)
        begin
            d.res1.last = 1'b1;
        end
    end

    assign dec = d;

endmodule

`default_nettype wire

// ===== bench/morse_text_decoder_test.sv =====
// ---------------------------------------------------------------------------
// Morse text decoder testbench
// Feeds dot/dash notation bytes through the slave stream and checks every
// result transfer against a cycle-free decoder kept alongside. Directed
// letters and the corner cases of separators, over-long letters and unknown
// bytes come first, then random text with idle bursts on both sides, a long
// receiver hold-off that backs the block up, and a final run with no gaps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module morse_text_decoder_test;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 40;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    // Decoder state as seen by the predictor
    logic [3:0] pend_bits = '0;
    logic [2:0] pend_count = '0;
    logic       halted = 1'b0;

    mtd_pkg::result_t step_results[$];
    mtd_pkg::result_t expected_results[$];

    // Letter alphabet, indexed by element bits plus 2^count - 1
    logic [7:0] alphabet [0:30] = '{
        8'h20,
        "E", "T", "I", "N", "A", "M", "S", "D", "R", "G",
        "U", "K", "W", "O", "H", "B", "L", "Z", "F", "C",
        "P", 8'hD6, "V", "X", 8'hC4, "Q", 8'hDC, "Y", "J", 8'h23
    };

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_hold = 0;
    int rx_gap = 0;

    int fail_count = 0;
    int cycle_count = 0;
    int bytes_sent = 0;
    int bytes_decoded = 0;
    int results_checked = 0;
    int chars_seen = 0;
    int ends_seen = 0;
    int errors_seen = 0;

    morse_text_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t ns: run stopped after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expected_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void push_result(input logic [7:0] code, input mtd_pkg::kind_t k);
        mtd_pkg::result_t r;
        r.char_code = code;
        r.kind      = k;
        r.last      = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void close_letter();
        logic [4:0] idx;
        if (pend_count != 3'd0)
        begin
            idx = 5'(pend_bits) + ((5'd1 << pend_count) - 5'd1);
            push_result(alphabet[idx], mtd_pkg::KIND_CHAR);
        end
        pend_bits  = '0;
        pend_count = '0;
    endfunction

    function automatic void decode_byte(input logic [7:0] text_byte);
        mtd_pkg::result_t tail;
        step_results.delete();
        if (halted)
        begin
            // Ignore everything but end of text
            if (text_byte == mtd_pkg::BYTE_NUL)
            begin
                halted     = 1'b0;
                pend_bits  = '0;
                pend_count = '0;
                push_result(mtd_pkg::CHAR_NONE, mtd_pkg::KIND_END);
                bytes_decoded++;
            end
        end
        else
        begin
            case (text_byte)
                mtd_pkg::BYTE_DOT, mtd_pkg::BYTE_DASH, mtd_pkg::BYTE_UNDERSCORE:
                begin
                    if (pend_count >= mtd_pkg::MAX_ELEMENTS)
                    begin
                        pend_bits  = '0;
                        pend_count = '0;
                        halted     = 1'b1;
                        push_result(mtd_pkg::CHAR_NONE, mtd_pkg::KIND_ERROR);
                    end
                    else
                    begin
                        if (text_byte != mtd_pkg::BYTE_DOT)
                            pend_bits[pend_count[1:0]] = 1'b1;
                        pend_count = pend_count + 3'd1;
                    end
                end
                mtd_pkg::BYTE_SPACE, mtd_pkg::BYTE_TAB,
                mtd_pkg::BYTE_LF, mtd_pkg::BYTE_CR:
                    close_letter();
                mtd_pkg::BYTE_SLASH:
                begin
                    close_letter();
                    push_result(mtd_pkg::CHAR_SPACE, mtd_pkg::KIND_CHAR);
                end
                mtd_pkg::BYTE_NUL:
                begin
                    close_letter();
                    push_result(mtd_pkg::CHAR_NONE, mtd_pkg::KIND_END);
                end
                default:
                begin
                    pend_bits  = '0;
                    pend_count = '0;
                    halted     = 1'b1;
                    push_result(mtd_pkg::CHAR_NONE, mtd_pkg::KIND_ERROR);
                end
            endcase
            bytes_decoded++;
        end
        if (step_results.size() > 0)
        begin
            tail = step_results.pop_back();
            tail.last = 1'b1;
            step_results.push_back(tail);
        end
        foreach (step_results[i])
            expected_results.push_back(step_results[i]);
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] text_byte);
        if (tx_idle && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= text_byte;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        decode_byte(text_byte);
        bytes_sent++;
    endtask

    function automatic logic [7:0] pick_element();
        case ($urandom_range(0, 2))
            0:       return mtd_pkg::BYTE_DOT;
            1:       return mtd_pkg::BYTE_DASH;
            default: return mtd_pkg::BYTE_UNDERSCORE;
        endcase
    endfunction

    function automatic logic [7:0] pick_separator();
        case ($urandom_range(0, 4))
            0:       return mtd_pkg::BYTE_SPACE;
            1:       return mtd_pkg::BYTE_TAB;
            2:       return mtd_pkg::BYTE_LF;
            3:       return mtd_pkg::BYTE_CR;
            default: return mtd_pkg::BYTE_SLASH;
        endcase
    endfunction

    task automatic send_letter(input int elements);
        repeat (elements)
            send_byte(pick_element());
    endtask

    task automatic send_token();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            send_letter($urandom_range(1, 4));
            send_byte(pick_separator());
        end
        else if (pick < 76)
            send_byte(pick_separator());
        else if (pick < 80)
        begin
            send_letter($urandom_range(1, 4));
            send_byte(mtd_pkg::BYTE_NUL);
        end
        else if (pick < 92)
        begin
            if (pick < 86)
            begin
                send_letter(4);
                send_byte(pick_element());
            end
            else
            begin
                send_letter($urandom_range(0, 3));
                send_byte(8'($urandom_range(0, 255)));
            end
            // Junk after an error, mostly ignored
            repeat ($urandom_range(0, 3))
                send_byte(8'($urandom_range(0, 255)));
            send_byte(mtd_pkg::BYTE_NUL);
        end
        else
            send_byte(mtd_pkg::BYTE_NUL);
    endtask

    // ------------------------------------------------------------------
    // Receiver
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end
        else if (rx_gap > 0)
        begin
            m_tready <= 1'b0;
            rx_gap = rx_gap - 1;
        end
        else if (rx_idle && $urandom_range(0, 4) == 0)
        begin
            m_tready <= 1'b0;
            rx_gap = $urandom_range(0, 7);
        end
        else
            m_tready <= 1'b1;
    end

    task automatic note_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %02h, got %02h",
                     $time, field, want, got);
    endtask

    always @(posedge clk)
    begin : check_results
        mtd_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t ns: result with none expected, got %02h kind %0d last %0d",
                             $time, m_tdata, m_tuser, m_tlast);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata !== want.char_code)
                    note_mismatch("char_code", want.char_code, m_tdata);
                if (m_tuser !== want.kind)
                    note_mismatch("kind", 8'(want.kind), 8'(m_tuser));
                if (m_tlast !== want.last)
                    note_mismatch("last", 8'(want.last), 8'(m_tlast));
                results_checked++;
                case (want.kind)
                    mtd_pkg::KIND_CHAR: chars_seen++;
                    mtd_pkg::KIND_END:  ends_seen++;
                    default:            errors_seen++;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_byte(mtd_pkg::BYTE_DOT);
        send_byte(mtd_pkg::BYTE_TAB);
        repeat (4)
            send_byte(mtd_pkg::BYTE_DASH);
        send_byte(mtd_pkg::BYTE_CR);
        // Separators with nothing pending
        send_byte(mtd_pkg::BYTE_SLASH);
        send_byte(mtd_pkg::BYTE_LF);
        send_byte(mtd_pkg::BYTE_NUL);
        send_byte(mtd_pkg::BYTE_DOT);
        send_byte(mtd_pkg::BYTE_UNDERSCORE);
        send_byte(mtd_pkg::BYTE_DOT);
        send_byte(mtd_pkg::BYTE_SLASH);
        // Fifth element, then a byte that must be dropped
        send_byte(mtd_pkg::BYTE_DASH);
        repeat (4)
            send_byte(mtd_pkg::BYTE_DOT);
        send_byte(8'h80);
        send_byte(mtd_pkg::BYTE_NUL);
        send_byte(8'hFF);
        send_byte(mtd_pkg::BYTE_NUL);
        send_byte(mtd_pkg::BYTE_DOT);
        send_byte(mtd_pkg::BYTE_NUL);
    endtask

    task automatic test_random_text(input int target);
        int start;
        start = bytes_decoded;
        while (bytes_decoded - start < target)
            send_token();
    endtask

    task automatic test_backpressure();
        // Keep offering while the receiver sits still long enough to fill the queue
        tx_idle = 1'b0;
        rx_hold = 300;
        repeat (40)
        begin
            send_letter($urandom_range(1, 4));
            send_byte(mtd_pkg::BYTE_SLASH);
        end
        tx_idle = 1'b1;
    endtask

    task automatic test_steady_stream();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        test_random_text(250);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_text(1400);
        test_backpressure();
        test_steady_stream();
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d notation bytes (%0d not ignored), checked %0d results:",
                 bytes_sent, bytes_decoded, results_checked);
        $display("  %0d characters, %0d end markers, %0d errors, %0d mismatches",
                 chars_seen, ends_seen, errors_seen, fail_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/mtd_pkg.sv
rtl/core/mtd_decode.sv
rtl/core/morse_text_decoder.sv
bench/morse_text_decoder_test.sv
